// ===== hdl/cfe_pkg.sv =====
// Shared types, constants and the byte-wise CRC-16/MODBUS step for the
// command frame encoder. No dependencies.
package cfe_pkg;

    // Input command codes
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_PARAM = 2'd1;
    localparam logic [1:0] CMD_END   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_HEAD = 2'd0;
    localparam logic [1:0] CFG_TAIL = 2'd1;

    localparam logic [7:0]  HEAD_RESET = 8'hEE;
    localparam logic [31:0] TAIL_RESET = 32'hFFFC_FFFF;

    localparam int HEAD_LEN = 1;
    localparam int TAIL_LEN = 4;
    localparam int HEAD_N   = (HEAD_LEN > 1) ? 1 : HEAD_LEN;
    localparam int TAIL_N   = (TAIL_LEN > 4) ? 4 : TAIL_LEN;

    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [15:0] CMD_HIGH_MASK = 16'hFF00;
    localparam logic [15:0] CMD_TWO_BYTE  = 16'hB100;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        JOB_START = 2'd0,
        JOB_PARAM = 2'd1,
        JOB_END   = 2'd2
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [15:0] word;
    } job_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== hdl/crc16_command_frame_encoder_unit.sv =====
// Top level of the command frame encoder: configuration registers, front end,
// job queue and byte-serial back end. Depends on cfe_pkg and the cfe_* modules.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------
//  input    | in_valid / in_stall | command[1:0], word[15:0]
//  output   | out_valid/out_stall | out_byte[7:0], last
//  config   | cfg_valid/cfg_ready | cfg_index[1:0], cfg_data[31:0]
//
// The back end sends one byte per cycle while the receiver does not stall: a
// start request yields two or three bytes, a parameter two and an end six, so
// the byte rate of the output register sets throughput. Requests are taken at one per cycle while the
// four-entry job queue has room; any request, even one that produces nothing,
// waits while the queue is full.
// Reset closes any open frame, empties the queue and restores the head and
// tail registers to 0xEE and 0xFFFCFFFF.
module crc16_command_frame_encoder_unit
    import cfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [15:0] word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [7:0]  frame_head_reg;
    logic [31:0] frame_tail_reg;
    logic        push;
    job_t        push_job;
    logic        queue_full;
    logic        pop;
    logic        head_valid;
    job_t        head_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_head_reg <= HEAD_RESET;
            frame_tail_reg <= TAIL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_HEAD: frame_head_reg <= cfg_data[7:0];
                CFG_TAIL: frame_tail_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    cfe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .word       (word),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    cfe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    cfe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_head (frame_head_reg),
        .frame_tail (frame_tail_reg),
        .job_valid  (head_valid),
        .job        (head_job),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .last       (last)
    );

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && queue_full))
        else $error("job pushed into a full queue");

    a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("job popped from an empty queue");

    a_last_is_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last && (TAIL_N == 4)) |-> (out_byte == frame_tail_reg[7:0]))
        else $error("final byte is not the last tail byte");

    a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> queue_full)
        else $error("input stalled with room in the queue");
`endif

endmodule

// ===== hdl/cfe_front.sv =====
// Front end: accepts requests, tracks the open frame and turns each request
// that produces bytes into a job for the queue. Depends on cfe_pkg.
module cfe_front
    import cfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [15:0] word,
    input  logic        queue_full,
    output logic        push,
    output job_t        push_job
);

    logic in_frame_reg;
    logic in_frame_next;
    logic accept;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;

    always_comb
    begin
        in_frame_next  = in_frame_reg;
        push           = 1'b0;
        push_job.kind  = JOB_START;
        push_job.word  = word;
        unique case (command)
            CMD_START:
            begin
                push          = accept;
                in_frame_next = 1'b1;
            end
            CMD_PARAM:
            begin
                push_job.kind = JOB_PARAM;
                push          = accept && in_frame_reg;
            end
            CMD_END:
            begin
                push_job.kind = JOB_END;
                push          = accept && in_frame_reg;
                in_frame_next = 1'b0;
            end
            default:
            begin
                // unused code: drop
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_frame_reg <= in_frame_next;
        end
    end

endmodule

// ===== hdl/cfe_queue.sv =====
// Short job queue between front and back end, so each side stalls on its own.
// Depends on cfe_pkg.
module cfe_queue
    import cfe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output job_t head_job
);

    job_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;

    assign full       = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== hdl/cfe_back.sv =====
// Back end: walks each queued job one byte per cycle unless the output stalls,
// keeps the running CRC and drives the output register. Depends on cfe_pkg.
module cfe_back
    import cfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  frame_head,
    input  logic [31:0] frame_tail,
    input  logic        job_valid,
    input  job_t        job,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        last
);

    logic [2:0]  idx_reg;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        last_reg;

    logic [7:0]  byte_c;
    logic        last_c;
    logic        final_c;
    logic        two_byte;
    logic        fire;
    logic [1:0]  tail_sel;

    assign two_byte = ((job.word & CMD_HIGH_MASK) == CMD_TWO_BYTE);
    assign tail_sel = idx_reg[1:0] - 2'd2;
    assign fire     = job_valid && (!out_valid_reg || !out_stall);
    assign pop      = fire && final_c;

    always_comb
    begin
        byte_c   = 8'h00;
        last_c   = 1'b0;
        final_c  = 1'b0;
        crc_next = crc_reg;
        unique case (job.kind)
            JOB_START:
            begin
                if (idx_reg < 3'(HEAD_N))
                begin
                    byte_c = frame_head;
                end
                else if (idx_reg == 3'(HEAD_N))
                begin
                    // new frame: restart the CRC on the command high byte
                    byte_c   = job.word[15:8];
                    crc_next = crc_byte(CRC_INIT, byte_c);
                    final_c  = !two_byte;
                end
                else
                begin
                    byte_c   = job.word[7:0];
                    crc_next = crc_byte(crc_reg, byte_c);
                    final_c  = 1'b1;
                end
            end
            JOB_PARAM:
            begin
                if (idx_reg == 3'd0)
                begin
                    byte_c = job.word[15:8];
                end
                else
                begin
                    byte_c  = job.word[7:0];
                    final_c = 1'b1;
                end
                crc_next = crc_byte(crc_reg, byte_c);
            end
            JOB_END:
            begin
                if (idx_reg == 3'd0)
                begin
                    byte_c = crc_reg[15:8];
                end
                else if (idx_reg == 3'd1)
                begin
                    byte_c  = crc_reg[7:0];
                    final_c = (TAIL_N == 0);
                end
                else
                begin
                    case (tail_sel)
                        2'd0:    byte_c = frame_tail[31:24];
                        2'd1:    byte_c = frame_tail[23:16];
                        2'd2:    byte_c = frame_tail[15:8];
                        default: byte_c = frame_tail[7:0];
                    endcase
                    final_c = (idx_reg == 3'(1 + TAIL_N));
                end
                last_c = final_c;
                if (final_c)
                begin
                    crc_next = CRC_INIT;
                end
            end
            default:
            begin
                final_c = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                idx_reg       <= final_c ? 3'd0 : idx_reg + 3'd1;
                crc_reg       <= crc_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_byte_reg <= byte_c;
            last_reg     <= last_c;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;

endmodule

// ===== tb/cfe_frame_checker.sv =====
// Scoreboard for the command frame encoder: watches the request, byte and
// register-write channels, predicts every frame byte and compares it.
// Depends on cfe_pkg for command codes, register indexes and frame constants.
module cfe_frame_checker
    import cfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  command,
    input  logic [15:0] word,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  out_byte,
    input  logic        last,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          mismatches,
    output int          pending
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_byte_t;

    frame_byte_t due_bytes[$];
    logic [7:0]  head_reg;
    logic [31:0] tail_reg;
    logic        frame_open;
    logic [15:0] frame_crc;
    int          error_total = 0;

    function automatic logic [15:0] modbus_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] acc;
        acc = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (acc[0])
                acc = (acc >> 1) ^ CRC_POLY;
            else
                acc = acc >> 1;
        end
        return acc;
    endfunction

    // Command and parameter bytes feed the running CRC; head, CRC and tail do not
    task automatic queue_data_byte(input logic [7:0] b);
        frame_crc = modbus_step(frame_crc, b);
        due_bytes.push_back('{data: b, last: 1'b0});
    endtask

    task automatic encode_request(input logic [1:0] cmd, input logic [15:0] w);
        case (cmd)
            CMD_START:
            begin
                // drop any open frame and restart the CRC
                frame_open = 1'b1;
                frame_crc  = CRC_INIT;
                if (HEAD_N > 0)
                    due_bytes.push_back('{data: head_reg, last: 1'b0});
                queue_data_byte(w[15:8]);
                if ((w & CMD_HIGH_MASK) == CMD_TWO_BYTE)
                    queue_data_byte(w[7:0]);
            end
            CMD_PARAM:
            begin
                if (frame_open)
                begin
                    queue_data_byte(w[15:8]);
                    queue_data_byte(w[7:0]);
                end
            end
            CMD_END:
            begin
                if (frame_open)
                begin
                    due_bytes.push_back('{data: frame_crc[15:8], last: 1'b0});
                    due_bytes.push_back('{data: frame_crc[7:0], last: (TAIL_N == 0)});
                    for (int i = 0; i < TAIL_N; i++)
                        due_bytes.push_back('{data: tail_reg[8 * (3 - i) +: 8],
                                              last: (i + 1 == TAIL_N)});
                    frame_open = 1'b0;
                    frame_crc  = CRC_INIT;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        frame_byte_t want;
        if (!rst_n)
        begin
            due_bytes.delete();
            head_reg   = HEAD_RESET;
            tail_reg   = TAIL_RESET;
            frame_open = 1'b0;
            frame_crc  = CRC_INIT;
            mismatches <= error_total;
            pending    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_HEAD)
                    head_reg = cfg_data[7:0];
                else if (cfg_index == CFG_TAIL)
                    tail_reg = cfg_data;
            end
            // Bytes leaving at this edge can only stem from earlier requests
            if (out_valid && !out_stall)
            begin
                if (due_bytes.size() == 0)
                begin
                    $error("out_byte: nothing expected, got %h (last %b)", out_byte, last);
                    error_total++;
                end
                else
                begin
                    want = due_bytes.pop_front();
                    if (out_byte !== want.data)
                    begin
                        $error("out_byte: expected %h, got %h", want.data, out_byte);
                        error_total++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %b, got %b", want.last, last);
                        error_total++;
                    end
                end
            end
            if (in_valid && !in_stall)
                encode_request(command, word);
            mismatches <= error_total;
            pending    <= due_bytes.size();
        end
    end

endmodule

// ===== tb/crc16_command_frame_encoder_unit_tb.sv =====
// Top of the command frame encoder testbench: clock, reset, request and
// register stimulus, receiver back-pressure and the verdict.
// Depends on cfe_pkg, the encoder RTL and cfe_frame_checker.
module crc16_command_frame_encoder_unit_tb
    import cfe_pkg::*;
();

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;

    localparam int RESET_CYCLES  = 12;
    localparam int DRAIN_CYCLES  = 24;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 70;
    localparam int TIMEOUT       = 4_000_000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [1:0]  command   = CMD_START;
    logic [15:0] word      = 16'h0000;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_HEAD;
    logic [31:0] cfg_data  = 32'h0;
    int          mismatches;
    int          pending;

    logic quiet     = 1'b0;
    logic hold_req  = 1'b0;
    logic stim_open = 1'b0;
    int   counted   = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    crc16_command_frame_encoder_unit dut (.*);

    cfe_frame_checker frame_check (.*);

    function automatic int sender_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic [15:0] random_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic send_request(input logic [1:0] cmd, input logic [15:0] w);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        word     <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // count only requests that the encoder acts upon
        if (cmd == CMD_START)
        begin
            stim_open = 1'b1;
            counted++;
        end
        else if (cmd == CMD_PARAM && stim_open)
            counted++;
        else if (cmd == CMD_END && stim_open)
        begin
            stim_open = 1'b0;
            counted++;
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_frame();
        int          n_params;
        logic [15:0] opcode;
        if ($urandom_range(0, 9) < 4)
            opcode = {8'hB1, 8'($urandom_range(0, 255))};
        else
            opcode = random_word();
        send_request(CMD_START, opcode);
        n_params = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 4) : $urandom_range(5, 12);
        repeat (n_params) send_request(CMD_PARAM, random_word());
        send_request(CMD_END, 16'($urandom_range(0, 65535)));
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 3))
            send_request(2'($urandom_range(0, 3)), random_word());
    endtask

    // Receiver back-pressure: random runs, a long hold-off on request, none when quiet
    initial
    begin
        int run;
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (quiet)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else if ($urandom_range(0, 99) < 65)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
                out_stall <= 1'b1;
                repeat (run) @(posedge clk);
            end
        end
    end

    initial
    begin
        int target;
        int r;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Requests outside a frame and the unused code produce nothing
        send_request(CMD_END, 16'h1234);
        send_request(CMD_PARAM, 16'hFFFF);
        send_request(CMD_UNUSED, 16'hFFFF);
        send_request(CMD_START, 16'h0000);
        send_request(CMD_PARAM, 16'h0000);
        send_request(CMD_PARAM, 16'hFFFF);
        send_request(CMD_END, 16'hFFFF);
        send_request(CMD_START, 16'hB1A5);
        send_request(CMD_PARAM, 16'h8001);
        send_request(CMD_END, 16'h0000);
        // restart inside an open frame, unused code inside a frame
        send_request(CMD_START, 16'hFFFF);
        send_request(CMD_START, 16'hB100);
        send_request(CMD_PARAM, 16'h1234);
        send_request(CMD_UNUSED, 16'h0000);
        send_request(CMD_END, 16'h5A5A);
        send_request(CMD_START, 16'hB0FF);
        send_request(CMD_END, 16'h0000);
        send_request(CMD_END, 16'h0000);
        send_request(CMD_START, 16'hB2FF);
        send_request(CMD_PARAM, 16'hFFFF);
        send_request(CMD_END, 16'h0000);
        send_request(CMD_START, 16'hB1FF);
        send_request(CMD_END, 16'h0000);

        for (int phase = 1; phase <= RANDOM_PHASES; phase++)
        begin
            wait_drained();
            case (phase)
                1:
                begin
                    write_register(CFG_HEAD, {24'($urandom), 8'h00});
                    write_register(CFG_TAIL, 32'h0000_0000);
                end
                2:
                begin
                    write_register(CFG_HEAD, {24'($urandom), 8'hFF});
                    write_register(CFG_TAIL, 32'hFFFF_FFFF);
                    write_register(CFG_SPARE_A, $urandom);
                    write_register(CFG_SPARE_B, $urandom);
                end
                default:
                begin
                    write_register(CFG_HEAD, $urandom);
                    write_register(CFG_TAIL, $urandom);
                end
            endcase
            quiet = (phase == 4);
            // hold the byte output long enough for the job queue to fill
            if (phase == 3)
                hold_req = 1'b1;
            target = counted + PHASE_ITEMS;
            while (counted < target)
            begin
                r = $urandom_range(0, 99);
                if (r < 80)
                    send_frame();
                else if (r < 96)
                    send_noise();
                else
                    wait_drained();
            end
            quiet = 1'b0;
        end

        wait_drained();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #(TIMEOUT);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
